// ===== rtl/brg_pkg.sv =====
// Package for the bearing angle block: shared types and fixed constants.
// No dependencies; every other file of the block imports it.
package brg_pkg;

   // CORDIC working width: |d| is placed with its top bit at bit 48 and grows by the CORDIC gain.
   localparam int DATA_W   = 52;
   localparam int PRESHIFT = 48;
   localparam int ANG_W    = 32;
   localparam int BEAR_W   = 16;
   localparam int OUT_SHIFT = 15;
   localparam int TAB_LEN  = 32;

   localparam logic signed [ANG_W-1:0] ANG_90  = 32'sd377487360;
   localparam logic signed [ANG_W-1:0] ANG_180 = 32'sd754974720;
   localparam logic signed [ANG_W-1:0] ANG_360 = 32'sd1509949440;

   localparam logic [BEAR_W-1:0] BEAR_90  = 16'd11520;
   localparam logic [BEAR_W-1:0] BEAR_180 = 16'd23040;
   localparam logic [BEAR_W-1:0] BEAR_270 = 16'd34560;
   localparam logic [BEAR_W-1:0] BEAR_360 = 16'd46080;

   // atan(2^-i) in units of 2^-22 degree.
   localparam logic signed [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
      32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
      32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
      32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
      32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
      32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
      32'sd229,       32'sd115,       32'sd57,       32'sd29,
      32'sd14,        32'sd7,         32'sd4,        32'sd2,
      32'sd1,         32'sd0,         32'sd0,        32'sd0
   };

   typedef struct packed {
      logic dx_zero;
      logic dx_neg;
      logic dy_zero;
      logic dy_pos;
   } brg_meta_type;

endpackage

// ===== rtl/brg_front.sv =====
// Input stage: forms the point differences, their magnitudes and quadrant flags.
// Depends on brg_pkg.
module brg_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 up_valid,
   input  logic signed [COORD_WIDTH-1:0]        from_x,
   input  logic signed [COORD_WIDTH-1:0]        from_y,
   input  logic signed [COORD_WIDTH-1:0]        to_x,
   input  logic signed [COORD_WIDTH-1:0]        to_y,
   output logic                                 dn_valid,
   output logic signed [brg_pkg::DATA_W-1:0]    dn_x,
   output logic signed [brg_pkg::DATA_W-1:0]    dn_y,
   output brg_pkg::brg_meta_type                dn_meta
);
   import brg_pkg::*;

   logic signed [COORD_WIDTH:0] dx;
   logic signed [COORD_WIDTH:0] dy;
   logic        [COORD_WIDTH:0] ax;
   logic        [COORD_WIDTH:0] ay;
   logic signed [DATA_W-1:0]    x_in, x_ff;
   logic signed [DATA_W-1:0]    y_in, y_ff;
   brg_meta_type                meta_in, meta_ff;
   logic                        valid_ff;

   always_comb begin
      dx = {to_x[COORD_WIDTH-1], to_x} - {from_x[COORD_WIDTH-1], from_x};
      dy = {to_y[COORD_WIDTH-1], to_y} - {from_y[COORD_WIDTH-1], from_y};
      ax = dx[COORD_WIDTH] ? -dx : dx;
      ay = dy[COORD_WIDTH] ? -dy : dy;
      x_in = {{(DATA_W-PRESHIFT-1){1'b0}}, ax, {(PRESHIFT-COORD_WIDTH){1'b0}}};
      y_in = {{(DATA_W-PRESHIFT-1){1'b0}}, ay, {(PRESHIFT-COORD_WIDTH){1'b0}}};
      meta_in.dx_zero = (dx == '0);
      meta_in.dx_neg  = dx[COORD_WIDTH];
      meta_in.dy_zero = (dy == '0);
      meta_in.dy_pos  = !dy[COORD_WIDTH] && (dy != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         meta_ff <= meta_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_meta  = meta_ff;

endmodule

// ===== rtl/brg_cell.sv =====
// One CORDIC vectoring iteration with its pipeline register.
// Depends on brg_pkg for widths, the arctangent table and the flag struct.
module brg_cell #(
   parameter int IDX = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 up_valid,
   input  logic signed [brg_pkg::DATA_W-1:0]    up_x,
   input  logic signed [brg_pkg::DATA_W-1:0]    up_y,
   input  logic signed [brg_pkg::ANG_W-1:0]     up_z,
   input  brg_pkg::brg_meta_type                up_meta,
   output logic                                 dn_valid,
   output logic signed [brg_pkg::DATA_W-1:0]    dn_x,
   output logic signed [brg_pkg::DATA_W-1:0]    dn_y,
   output logic signed [brg_pkg::ANG_W-1:0]     dn_z,
   output brg_pkg::brg_meta_type                dn_meta
);
   import brg_pkg::*;

   logic signed [DATA_W-1:0] xs;
   logic signed [DATA_W-1:0] ys;
   logic signed [DATA_W-1:0] x_in, x_ff;
   logic signed [DATA_W-1:0] y_in, y_ff;
   logic signed [ANG_W-1:0]  z_in, z_ff;
   brg_meta_type             meta_ff;
   logic                     valid_ff;

   always_comb begin
      xs = up_x >>> IDX;
      ys = up_y >>> IDX;
      if (!up_y[DATA_W-1]) begin
         x_in = up_x + ys;
         y_in = up_y - xs;
         z_in = up_z + ATAN_TAB[IDX];
      end else begin
         x_in = up_x - ys;
         y_in = up_y + xs;
         z_in = up_z - ATAN_TAB[IDX];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         meta_ff <= up_meta;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_z     = z_ff;
   assign dn_meta  = meta_ff;

endmodule

// ===== rtl/brg_back.sv =====
// Output stage: clamps the CORDIC angle, folds it into its quadrant, rounds it
// to 1/128 degree and holds the result beat. Depends on brg_pkg.
module brg_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 up_valid,
   input  logic signed [brg_pkg::ANG_W-1:0]     up_z,
   input  brg_pkg::brg_meta_type                up_meta,
   output logic                                 rsp_valid,
   output logic [brg_pkg::BEAR_W-1:0]           rsp_bearing
);
   import brg_pkg::*;

   logic signed [ANG_W-1:0]  t;
   logic        [ANG_W-1:0]  fine;
   logic        [ANG_W:0]    rounded;
   logic        [BEAR_W-1:0] bearing_in, bearing_ff;
   logic                     valid_ff;

   always_comb begin
      if (up_meta.dy_zero || up_z[ANG_W-1]) begin
         t = '0;
      end else if (up_z > ANG_90) begin
         t = ANG_90;
      end else begin
         t = up_z;
      end
      if (!up_meta.dx_neg) begin
         fine = up_meta.dy_pos ? t : ANG_360 - t;
      end else begin
         fine = up_meta.dy_pos ? ANG_180 - t : ANG_180 + t;
      end
      rounded = ({1'b0, fine} + (ANG_W+1)'(1 << (OUT_SHIFT-1))) >> OUT_SHIFT;
      if (up_meta.dx_zero) begin
         bearing_in = up_meta.dy_pos ? BEAR_90 : BEAR_270;
      end else if (rounded > (ANG_W+1)'(BEAR_360)) begin
         bearing_in = BEAR_360;
      end else begin
         bearing_in = rounded[BEAR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bearing_ff <= bearing_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_bearing = bearing_ff;

   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> bearing_ff <= BEAR_360)
      else $error("bearing beyond a full turn");

   a_vertical: assert property (@(posedge clock) disable iff (reset)
      en && up_valid && up_meta.dx_zero |=>
         bearing_ff == BEAR_90 || bearing_ff == BEAR_270)
      else $error("vertical case not folded to 90 or 270 degrees");

   a_horizontal: assert property (@(posedge clock) disable iff (reset)
      en && up_valid && up_meta.dy_zero && !up_meta.dx_zero |=>
         bearing_ff == BEAR_360 || bearing_ff == BEAR_180)
      else $error("horizontal case not folded to 180 or 360 degrees");

endmodule

// ===== rtl/bearing_angle_degrees.sv =====
// Bearing from one point to another: a pipelined CORDIC atan2 folded into [0,360] degrees.
// Depends on brg_pkg, brg_front, brg_cell and brg_back.
//
// The block takes one beat of two Q12.4 points per cycle while req_stall is low and
// returns the bearing of the second point as seen from the first, in 1/128 degree
// (46080 is 360). Each beat passes through the registered stages in order: the
// difference stage, the CORDIC cells, and the fold and rounding stage.
// The pipeline advances as a whole; it halts only while a result beat waits
// under rsp_stall, and then req_stall is raised in the same cycle.
module bearing_angle_degrees #(
   parameter int COORD_WIDTH   = 16,
   parameter int CORDIC_STAGES = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_from_x,
   input  logic signed [COORD_WIDTH-1:0] req_from_y,
   input  logic signed [COORD_WIDTH-1:0] req_to_x,
   input  logic signed [COORD_WIDTH-1:0] req_to_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brg_pkg::BEAR_W-1:0]    rsp_bearing
);
   import brg_pkg::*;

   logic                     en;
   logic                     v_chain    [CORDIC_STAGES+1];
   logic signed [DATA_W-1:0] x_chain    [CORDIC_STAGES+1];
   logic signed [DATA_W-1:0] y_chain    [CORDIC_STAGES+1];
   logic signed [ANG_W-1:0]  z_chain    [CORDIC_STAGES+1];
   brg_meta_type             meta_chain [CORDIC_STAGES+1];

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign z_chain[0] = '0;

   brg_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .up_valid (req_valid),
      .from_x   (req_from_x),
      .from_y   (req_from_y),
      .to_x     (req_to_x),
      .to_y     (req_to_y),
      .dn_valid (v_chain[0]),
      .dn_x     (x_chain[0]),
      .dn_y     (y_chain[0]),
      .dn_meta  (meta_chain[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      brg_cell #(
         .IDX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_valid (v_chain[i]),
         .up_x     (x_chain[i]),
         .up_y     (y_chain[i]),
         .up_z     (z_chain[i]),
         .up_meta  (meta_chain[i]),
         .dn_valid (v_chain[i+1]),
         .dn_x     (x_chain[i+1]),
         .dn_y     (y_chain[i+1]),
         .dn_z     (z_chain[i+1]),
         .dn_meta  (meta_chain[i+1])
      );
   end

   brg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .up_valid    (v_chain[CORDIC_STAGES]),
      .up_z        (z_chain[CORDIC_STAGES]),
      .up_meta     (meta_chain[CORDIC_STAGES]),
      .rsp_valid   (rsp_valid),
      .rsp_bearing (rsp_bearing)
   );

endmodule
